// File: rtl/ttpc_pkg.sv
// Shared types, codes and fixed-point helpers for the timed travel position controller.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package ttpc_pkg;

	localparam int AMT_W = 25;          // unsigned Q1.24 field; positions use 0..1.0 inclusive
	localparam int POS_W = 27;          // signed estimate and target
	localparam int WIDE_W = 28;         // working width for sums and differences
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_PER_TICK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_OVERSHOOT = 1'd1;

	localparam logic [AMT_W-1:0] STEP_RESET = 25'd1678;
	localparam logic [AMT_W-1:0] OVERSHOOT_RESET = 25'd0;

	localparam logic [2:0] MODE_TICK = 3'd0;
	localparam logic [2:0] MODE_FWD = 3'd1;
	localparam logic [2:0] MODE_REV = 3'd2;
	localparam logic [2:0] MODE_MOVE_TO = 3'd3;
	localparam logic [2:0] MODE_STOP = 3'd4;
	localparam logic [2:0] MODE_START = 3'd5;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FWD = 2'd1;
	localparam logic [1:0] ST_REV = 2'd2;
	localparam logic [1:0] ST_REACHED = 2'd3;

	localparam logic [AMT_W-1:0] Q_ONE_U = 25'h1000000;
	localparam logic signed [WIDE_W-1:0] Q_ONE_W = 28'sh1000000;
	localparam logic signed [WIDE_W-1:0] LIMIT_W = 28'sh2000000;
	localparam logic signed [POS_W-1:0] LIMIT_P = 27'sh2000000;

	typedef struct packed {
		logic [2:0]       mode;
		logic [AMT_W-1:0] amount;
	} cmd_t;

	typedef struct packed {
		logic             motor_forward;
		logic             motor_reverse;
		logic [1:0]       run_state;
		logic [AMT_W-1:0] position_now;
		logic             accepted;
	} res_t;

	// saturate a computed target to -2.0..2.0
	function automatic logic signed [POS_W-1:0] sat_target(input logic signed [WIDE_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > LIMIT_W) begin
			r = LIMIT_P;
		end else if (v < -LIMIT_W) begin
			r = -LIMIT_P;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	// clamp to 0..1.0, result always fits the unsigned Q24 field
	function automatic logic [AMT_W-1:0] clamp_unit(input logic signed [WIDE_W-1:0] v);
		logic [AMT_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > Q_ONE_W) begin
			r = Q_ONE_U;
		end else begin
			r = v[AMT_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/timed_travel_position_controller_top.sv
// Top level: input register, estimator core, result register and configuration.
// Depends on ttpc_pkg, ttpc_cfg and ttpc_core.
`timescale 1ns / 1ps
// Timing: the estimator update is a single pass of adds and compares; an accepted beat waits
// in the input register until the result register can take its result, and out_valid rises.
// Throughput: one beat per cycle unless out_stall holds a full result register.
// Reset (arst_n, asynchronous): estimate and target zero, idle, start position unset,
// step 1678 and overshoot zero; both pipeline stages empty.

module timed_travel_position_controller_top import ttpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cmd_t                 in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output res_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [AMT_W-1:0]     cfg_data
);

	logic             valid_s1;
	cmd_t             cmd_s1;
	logic             out_valid_q;
	res_t             out_q;
	logic             adv;
	res_t             res;
	logic [AMT_W-1:0] step_per_tick;
	logic [AMT_W-1:0] end_overshoot;

	// command moves on whenever the result register is free or being drained
	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	ttpc_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.step_per_tick (step_per_tick),
		.end_overshoot (end_overshoot)
	);

	ttpc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (adv),
		.cmd           (cmd_s1),
		.step_per_tick (step_per_tick),
		.end_overshoot (end_overshoot),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// File: rtl/ttpc_cfg.sv
// Configuration registers: travel step per tick and end overshoot.
// Depends on ttpc_pkg.
`timescale 1ns / 1ps

module ttpc_cfg import ttpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [AMT_W-1:0]     cfg_data,
	output logic [AMT_W-1:0]     step_per_tick,
	output logic [AMT_W-1:0]     end_overshoot
);

	logic [AMT_W-1:0] step_q;
	logic [AMT_W-1:0] ovs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			ovs_q <= OVERSHOOT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_PER_TICK: step_q <= cfg_data;
				REG_END_OVERSHOOT: ovs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign step_per_tick = step_q;
	assign end_overshoot = ovs_q;

endmodule

// File: rtl/ttpc_core.sv
// Position estimator state and per-command update logic; result is combinational.
// Depends on ttpc_pkg.
`timescale 1ns / 1ps

module ttpc_core import ttpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  cmd_t             cmd,
	input  logic [AMT_W-1:0] step_per_tick,
	input  logic [AMT_W-1:0] end_overshoot,
	output res_t             res
);

	logic signed [POS_W-1:0] pos_q, tgt_q;
	logic [1:0]              st_q;
	logic                    started_q;

	logic signed [POS_W-1:0] pos_d, tgt_d;
	logic [1:0]              st_d;
	logic                    started_d;
	logic                    ok;

	logic signed [WIDE_W-1:0] pos_w, tgt_w, amt_w, step_w, ovs_w;
	logic signed [WIDE_W-1:0] dest_w, pcl_w, end_w, np_w, diff_w;
	logic signed [POS_W-1:0]  rel_dest;
	logic [AMT_W-1:0]         pos_cl, np_cl;
	logic                     go_fwd, move_ok;

	always_comb begin
		pos_w = {pos_q[POS_W-1], pos_q};
		tgt_w = {tgt_q[POS_W-1], tgt_q};
		amt_w = {3'b000, cmd.amount};
		step_w = {3'b000, step_per_tick};
		ovs_w = {3'b000, end_overshoot};
		pos_cl = clamp_unit(pos_w);
		pcl_w = {3'b000, pos_cl};
		move_ok = (cmd.amount != '0) && (cmd.amount <= Q_ONE_U);

		// relative moves start from the unclamped estimate
		rel_dest = sat_target((cmd.mode == MODE_REV) ? pos_w - amt_w : pos_w + amt_w);
		case (cmd.mode)
			MODE_FWD, MODE_REV: dest_w = {rel_dest[POS_W-1], rel_dest};
			default:  dest_w = amt_w;
		endcase

		// equal target runs reverse; end targets pushed past the stop
		go_fwd = dest_w > pcl_w;
		if (go_fwd) begin
			end_w = (dest_w == Q_ONE_W) ? dest_w + ovs_w : dest_w;
		end else begin
			end_w = (dest_w == '0) ? dest_w - ovs_w : dest_w;
		end

		np_w = (st_q == ST_FWD) ? pos_w + step_w : pos_w - step_w;
		diff_w = (st_q == ST_FWD) ? np_w - tgt_w : tgt_w - np_w;
		np_cl = clamp_unit(np_w);
	end

	always_comb begin
		pos_d = pos_q;
		tgt_d = tgt_q;
		st_d = st_q;
		started_d = started_q;
		ok = 1'b0;
		case (cmd.mode)
			MODE_TICK: begin
				ok = 1'b1;
				if (st_q inside {ST_FWD, ST_REV}) begin
					pos_d = np_w[POS_W-1:0];
					if (!diff_w[WIDE_W-1]) begin
						pos_d = {2'b00, np_cl};
						st_d = ST_REACHED;
					end
				end
			end
			MODE_FWD, MODE_REV, MODE_MOVE_TO: begin
				if ((cmd.mode == MODE_MOVE_TO) ? (cmd.amount <= Q_ONE_U) : move_ok) begin
					ok = 1'b1;
					pos_d = {2'b00, pos_cl};
					st_d = go_fwd ? ST_FWD : ST_REV;
					tgt_d = sat_target(end_w);
				end
			end
			MODE_STOP: begin
				ok = 1'b1;
				st_d = ST_IDLE;
			end
			MODE_START: begin
				if (!started_q) begin
					ok = 1'b1;
					started_d = 1'b1;
					pos_d = {2'b00, cmd.amount};
					st_d = ST_IDLE;
				end
			end
			default: ;
		endcase

		res.motor_forward = (st_d == ST_FWD);
		res.motor_reverse = (st_d == ST_REV);
		res.run_state = st_d;
		res.position_now = clamp_unit({pos_d[POS_W-1], pos_d});
		res.accepted = ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			tgt_q <= '0;
			st_q <= ST_IDLE;
			started_q <= 1'b0;
		end else if (fire) begin
			pos_q <= pos_d;
			tgt_q <= tgt_d;
			st_q <= st_d;
			started_q <= started_d;
		end
	end

`ifndef SYNTHESIS
	a_started_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("start flag cleared");

	a_target_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tgt_q <= LIMIT_P) && (tgt_q >= -LIMIT_P))
		else $error("target beyond saturation limit");

	a_stop_idles: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd.mode == MODE_STOP) |=> (st_q == ST_IDLE))
		else $error("stop did not idle the motor");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !res.accepted |=> $stable(pos_q) && $stable(tgt_q) && $stable(st_q))
		else $error("rejected command changed state");
`endif

endmodule

// File: verif/timed_travel_position_controller_top_test.sv
// Self-checking bench for timed_travel_position_controller_top: a short directed script,
// then random move/tick sequences under several step and overshoot settings.
// Depends on ttpc_pkg and the top level; keeps its own model of the position estimate.
`timescale 1ns / 1ps

module timed_travel_position_controller_top_test;
	import ttpc_pkg::*;

	localparam logic signed [27:0] FULL_TRAVEL = 28'sd16777216;
	localparam logic signed [27:0] TGT_HI = 28'sd33554432;
	localparam logic signed [27:0] TGT_LO = -28'sd33554432;
	localparam logic [24:0] AMT_MAX = 25'h1FFFFFF;
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;
	localparam int QUIET_LIMIT = 400;
	localparam int PHASES = 7;
	localparam int ITEMS_PER_PHASE = 290;

	typedef struct packed {
		cmd_t cmd;
		logic fixed;
		res_t want;
	} row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	cmd_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	res_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_PER_TICK;
	logic [AMT_W-1:0] cfg_data = '0;

	// model of the estimator
	logic signed [26:0] est_pos = '0;
	logic signed [26:0] tgt_pos = '0;
	logic [1:0] drive_state = ST_IDLE;
	logic start_taken = 1'b0;
	logic [24:0] step_cfg = STEP_RESET;
	logic [24:0] overshoot_cfg = OVERSHOOT_RESET;

	res_t due_results[$];
	row_t script[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int n_cmds = 0;
	int n_reached = 0;
	int n_refused = 0;
	int n_settings = 1;
	bit sender_calm = 1'b0;

	timed_travel_position_controller_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [24:0] unit_clamp(input logic signed [27:0] v);
		if (v < 0) return '0;
		if (v > FULL_TRAVEL) return Q_ONE_U;
		return v[24:0];
	endfunction

	function automatic logic signed [26:0] bound_target(input logic signed [27:0] v);
		if (v > TGT_HI) return TGT_HI[26:0];
		if (v < TGT_LO) return TGT_LO[26:0];
		return v[26:0];
	endfunction

	// estimate is clamped before the direction is chosen; end targets get the overshoot
	function void start_move(input logic signed [27:0] dest);
		logic signed [27:0] d;
		d = dest;
		est_pos = {2'b00, unit_clamp(28'(est_pos))};
		if (d > est_pos) begin
			drive_state = ST_FWD;
			if (d == FULL_TRAVEL) d = d + $signed({3'b000, overshoot_cfg});
		end else begin
			drive_state = ST_REV;
			if (d == 0) d = d - $signed({3'b000, overshoot_cfg});
		end
		tgt_pos = bound_target(d);
	endfunction

	function void tick_motor();
		logic signed [27:0] w;
		logic signed [27:0] left;
		w = 28'(est_pos);
		if (drive_state == ST_FWD) begin
			w = w + $signed({3'b000, step_cfg});
			left = w - tgt_pos;
		end else if (drive_state == ST_REV) begin
			w = w - $signed({3'b000, step_cfg});
			left = tgt_pos - w;
		end else begin
			return;
		end
		est_pos = w[26:0];
		if (left >= 0) begin
			est_pos = {2'b00, unit_clamp(w)};
			drive_state = ST_REACHED;
			n_reached++;
		end
	endfunction

	function res_t step_estimator(input cmd_t c);
		res_t r;
		logic ok;
		logic len_ok;
		ok = 1'b0;
		len_ok = (c.amount != 0) && (c.amount <= Q_ONE_U);
		case (c.mode)
			MODE_TICK: begin
				tick_motor();
				ok = 1'b1;
			end
			MODE_FWD: begin
				if (len_ok) begin
					start_move(28'(bound_target(est_pos + $signed({3'b000, c.amount}))));
					ok = 1'b1;
				end
			end
			MODE_REV: begin
				if (len_ok) begin
					start_move(28'(bound_target(est_pos - $signed({3'b000, c.amount}))));
					ok = 1'b1;
				end
			end
			MODE_MOVE_TO: begin
				if (c.amount <= Q_ONE_U) begin
					start_move($signed({3'b000, c.amount}));
					ok = 1'b1;
				end
			end
			MODE_STOP: begin
				drive_state = ST_IDLE;
				ok = 1'b1;
			end
			MODE_START: begin
				// only the first one counts; the estimate is loaded unclamped
				if (!start_taken) begin
					start_taken = 1'b1;
					est_pos = {2'b00, c.amount};
					drive_state = ST_IDLE;
					ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.motor_forward = drive_state == ST_FWD;
		r.motor_reverse = drive_state == ST_REV;
		r.run_state = drive_state;
		r.position_now = unit_clamp(28'(est_pos));
		r.accepted = ok;
		n_cmds++;
		if (!ok) n_refused++;
		return r;
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic send_beat(input cmd_t c, input logic fixed, input res_t want);
		int gap;
		res_t guess;
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		do @(posedge clk); while (in_stall);
		guess = step_estimator(c);
		due_results.push_back(fixed ? want : guess);
	endtask

	task automatic send_cmd(input logic [2:0] m, input logic [24:0] a);
		cmd_t c;
		c.mode = m;
		c.amount = a;
		send_beat(c, 1'b0, '0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	task automatic load_settings(input logic [24:0] step, input logic [24:0] over);
		cfg_we <= 1'b1;
		cfg_index <= REG_STEP_PER_TICK;
		cfg_data <= step;
		@(posedge clk);
		cfg_index <= REG_END_OVERSHOOT;
		cfg_data <= over;
		@(posedge clk);
		cfg_we <= 1'b0;
		step_cfg = step;
		overshoot_cfg = over;
		n_settings++;
	endtask

	function void add_row(input logic [2:0] m, input logic [24:0] a);
		row_t r;
		r.cmd.mode = m;
		r.cmd.amount = a;
		r.fixed = 1'b0;
		r.want = '0;
		script.push_back(r);
	endfunction

	function void add_check(input logic [2:0] m, input logic [24:0] a, input logic [1:0] st,
			input logic [24:0] p, input logic ok);
		row_t r;
		r.cmd.mode = m;
		r.cmd.amount = a;
		r.fixed = 1'b1;
		r.want.motor_forward = st == ST_FWD;
		r.want.motor_reverse = st == ST_REV;
		r.want.run_state = st;
		r.want.position_now = p;
		r.want.accepted = ok;
		script.push_back(r);
	endfunction

	// many lengths are one to sixteen steps long so that ticks actually finish moves
	function automatic logic [24:0] move_length();
		int r;
		longint span;
		r = $urandom_range(0, 99);
		if (r < 6) return '0;
		if (r < 12) return Q_ONE_U;
		if (r < 16) return 25'd1;
		if (r < 22) return 25'($urandom_range(Q_ONE_U + 1, AMT_MAX));
		if (r < 60 && step_cfg != 0) begin
			span = longint'(step_cfg) * $urandom_range(1, 16);
			return (span > Q_ONE_U) ? Q_ONE_U : span[24:0];
		end
		return 25'($urandom_range(1, Q_ONE_U));
	endfunction

	function automatic logic [24:0] move_target();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 30) return Q_ONE_U;
		if (r < 36) return 25'($urandom_range(Q_ONE_U + 1, AMT_MAX));
		if (r < 44) return unit_clamp(28'(est_pos));
		return 25'($urandom_range(0, Q_ONE_U));
	endfunction

	// one move command followed by a run of ticks, with some noise mixed in
	task automatic run_phase(input int items);
		int sent;
		int r;
		int ticks;
		int pause_at;
		sent = 0;
		pause_at = $urandom_range(items / 4, items / 2);
		while (sent < items) begin
			if ($urandom_range(0, 9) == 0) sender_calm = !sender_calm;
			r = $urandom_range(0, 99);
			if (r < 25) begin
				send_cmd(MODE_FWD, move_length());
			end else if (r < 50) begin
				send_cmd(MODE_REV, move_length());
			end else if (r < 85) begin
				send_cmd(MODE_MOVE_TO, move_target());
			end else if (r < 90) begin
				send_cmd(MODE_STOP, 25'($urandom()));
			end else if (r < 92) begin
				send_cmd(MODE_START, 25'($urandom()));
			end else begin
				send_cmd(3'($urandom_range(0, 7)), 25'($urandom()));
			end
			ticks = $urandom_range(0, 30);
			sent += ticks + 1;
			repeat (ticks) begin
				if ($urandom_range(0, 59) == 0) begin
					send_cmd(MODE_STOP, '0);
				end else begin
					send_cmd(MODE_TICK, 25'($urandom()));
				end
			end
			if (pause_at >= 0 && sent >= pause_at) begin
				drain();
				pause_at = -1;
			end
		end
	endtask

	function void check_field(input string name, input logic [24:0] want, input logic [24:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, out_data);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("motor_forward", 25'(want.motor_forward),
						25'(out_data.motor_forward));
					check_field("motor_reverse", 25'(want.motor_reverse),
						25'(out_data.motor_reverse));
					check_field("run_state", 25'(want.run_state), 25'(out_data.run_state));
					check_field("position_now", want.position_now, out_data.position_now);
					check_field("accepted", 25'(want.accepted), 25'(out_data.accepted));
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		int hold;
		forever begin
			if ($urandom_range(0, 29) == 0) begin
				out_stall <= 1'b0;
				repeat (60) @(posedge clk);
			end else begin
				hold = pick_gap(1'b0);
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
		$display("timed_travel_position_controller_top_test: errors");
		$finish;
	end

	initial begin
		// before any start position: an idle tick, refusals, then target equal to estimate at zero
		add_check(MODE_TICK, '0, ST_IDLE, '0, 1'b1);
		add_check(MODE_SPARE_A, AMT_MAX, ST_IDLE, '0, 1'b0);
		add_check(MODE_SPARE_B, '0, ST_IDLE, '0, 1'b0);
		add_check(MODE_FWD, '0, ST_IDLE, '0, 1'b0);
		add_check(MODE_FWD, Q_ONE_U + 25'd1, ST_IDLE, '0, 1'b0);
		add_check(MODE_REV, '0, ST_IDLE, '0, 1'b0);
		add_check(MODE_MOVE_TO, AMT_MAX, ST_IDLE, '0, 1'b0);
		add_check(MODE_MOVE_TO, '0, ST_REV, '0, 1'b1);
		add_check(MODE_TICK, '0, ST_REACHED, '0, 1'b1);
		add_check(MODE_FWD, Q_ONE_U, ST_FWD, '0, 1'b1);
		add_row(MODE_TICK, '0);
		add_row(MODE_STOP, '0);
		// unclamped start near 2.0, then a second start that must be ignored
		add_check(MODE_START, AMT_MAX, ST_IDLE, Q_ONE_U, 1'b1);
		add_check(MODE_START, '0, ST_IDLE, Q_ONE_U, 1'b0);
		add_check(MODE_TICK, AMT_MAX, ST_IDLE, Q_ONE_U, 1'b1);
		add_row(MODE_FWD, Q_ONE_U);
		add_row(MODE_TICK, '0);
		add_row(MODE_REV, 25'd1);
		add_row(MODE_MOVE_TO, Q_ONE_U);
		add_row(MODE_TICK, '0);
		add_row(MODE_REV, Q_ONE_U);
		add_row(MODE_TICK, '0);
		add_row(MODE_STOP, AMT_MAX);
		add_row(MODE_MOVE_TO, 25'd1);
		add_row(MODE_TICK, '0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i]) send_beat(script[i].cmd, script[i].fixed, script[i].want);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: load_settings(Q_ONE_U, Q_ONE_U);
				1: load_settings(25'd1, '0);
				2: load_settings('0, 25'd4096);
				3: load_settings(AMT_MAX, AMT_MAX);
				default: load_settings(25'($urandom_range(16384, 4194304)),
					25'($urandom_range(0, Q_ONE_U)));
			endcase
			run_phase(p == 2 ? 120 : ITEMS_PER_PHASE);
		end
		drain();
		repeat (6) @(posedge clk);

		$display("%0d commands over %0d register settings: %0d moves completed, %0d refused",
			n_cmds, n_settings, n_reached, n_refused);
		if (mismatches == 0) begin
			$display("timed_travel_position_controller_top_test: clean");
		end else begin
			$display("timed_travel_position_controller_top_test: errors");
		end
		$finish;
	end

endmodule
